// ===== hw/rtl/pusb_pkg.sv =====
package pusb_pkg;

  // Line store capacity in bytes
  localparam int unsigned MAX_ROW_BYTES = 32768;
  localparam int unsigned STORE_AW      = $clog2(MAX_ROW_BYTES);

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned SLOT_W    = 17;
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned SLOTS_W   = 18;
  localparam int unsigned POS_W     = 17;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] FILTER_TYPE_UP = 8'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_OUTPUT_PIXELS = 2'd1,
    REG_ROW_TOTAL     = 2'd2,
    REG_RGB_MODE      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CFG_W-1:0] source_width;
    logic [CFG_W-1:0] output_pixels;
    logic [CFG_W-1:0] row_total;
    logic             rgb_mode;
  } cfg_t;

  // One classified slot, as handed from front to back
  typedef struct packed {
    logic                ft;        // emit the filter type byte first
    logic                px;        // emit a pixel byte
    logic [STORE_AW-1:0] addr;
    logic                in_store;
    logic                first_row;
    logic [7:0]          cur;
    logic                last;
    logic                img_last;
    logic                ce;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_filter_type;
    logic       row_end;
    logic       image_end;
    logic       config_error;
  } result_t;

endpackage

// ===== hw/rtl/pusb_sub_if.sv =====
interface pusb_sub_if;
  logic       valid;
  logic       ready;
  logic [7:0] subpixel;

  modport source (output valid, output subpixel, input ready);
  modport sink   (input valid, input subpixel, output ready);
endinterface

// ===== hw/rtl/pusb_line_if.sv =====
interface pusb_line_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_filter_type;
  logic       row_end;
  logic       image_end;
  logic       config_error;

  modport source (output valid, output out_byte, output is_filter_type, output row_end,
                  output image_end, output config_error, input ready);
  modport sink   (input valid, input out_byte, input is_filter_type, input row_end,
                  input image_end, input config_error, output ready);
endinterface

// ===== hw/rtl/pusb_front.sv =====
module pusb_front import pusb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cfg_t         cfg_i,
  input  logic         valid_i,
  input  logic [7:0]   subpixel_i,
  output logic         ready_o,
  input  logic         q_ready_i,
  output logic         push_o,
  output cmd_t         cmd_o
);

  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               first_q, first_d;
  logic [7:0]         held_q;

  logic [CFG_W-1:0]   pix, rows;
  logic [SLOTS_W-1:0] pix3, pix2, slots, row_bytes, gap;
  logic [SLOT_W-1:0]  pad, rel;
  logic [POS_W-1:0]   pos;
  logic [7:0]         val, a, b;
  logic [8:0]         sum;
  logic               accept, last, img_last, hold, in_src;

  assign accept  = valid_i && q_ready_i;
  assign ready_o = q_ready_i;

  always_comb begin
    pix  = (cfg_i.output_pixels == '0) ? CFG_W'(1) : cfg_i.output_pixels;
    rows = (cfg_i.row_total == '0) ? CFG_W'(1) : cfg_i.row_total;
    pix2 = SLOTS_W'({pix, 1'b0});
    pix3 = pix2 + SLOTS_W'(pix);
    slots     = cfg_i.rgb_mode ? pix3 : pix2;
    row_bytes = cfg_i.rgb_mode ? pix3 : SLOTS_W'(pix);
    gap = slots - SLOTS_W'(cfg_i.source_width);
    pad = (slots > SLOTS_W'(cfg_i.source_width)) ? gap[SLOTS_W-1:1] : '0;
    rel = slot_q - pad;
    in_src = (slot_q >= pad) && (rel < SLOT_W'(cfg_i.source_width));
    val = in_src ? subpixel_i : 8'd0;

    last     = (SLOTS_W'(slot_q) + SLOTS_W'(1)) >= slots;
    img_last = last && ((ROW_W'(row_q) + 17'(1)) >= 17'(rows));

    // Grey: an even slot is held for its partner unless it closes the row
    hold = !cfg_i.rgb_mode && !slot_q[0] && !last;
    a    = slot_q[0] ? held_q : val;
    b    = slot_q[0] ? val : 8'd0;
    sum  = {1'b0, a} + {1'b0, b};
    pos  = cfg_i.rgb_mode ? slot_q : (slot_q >> 1);

    cmd_o.ft        = (slot_q == '0);
    cmd_o.px        = !hold;
    cmd_o.addr      = pos[STORE_AW-1:0];
    cmd_o.in_store  = pos < POS_W'(MAX_ROW_BYTES);
    cmd_o.first_row = first_q;
    cmd_o.cur       = cfg_i.rgb_mode ? val : sum[8:1];
    cmd_o.last      = last;
    cmd_o.img_last  = img_last;
    cmd_o.ce        = row_bytes > SLOTS_W'(MAX_ROW_BYTES);

    slot_d  = slot_q;
    row_d   = row_q;
    first_d = first_q;
    if (accept) begin
      if (last) begin
        slot_d = '0;
        if (img_last) begin
          row_d   = '0;
          first_d = 1'b1;
        end else begin
          row_d   = row_q + ROW_W'(1);
          first_d = 1'b0;
        end
      end else begin
        slot_d = slot_q + SLOT_W'(1);
      end
    end
  end

  assign push_o = accept && (cmd_o.ft || cmd_o.px);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      row_q   <= '0;
      first_q <= 1'b1;
      held_q  <= '0;
    end else begin
      slot_q  <= slot_d;
      row_q   <= row_d;
      first_q <= first_d;
      if (accept && hold) begin
        held_q <= val;
      end
    end
  end

endmodule

// ===== hw/rtl/pusb_queue.sv =====
module pusb_queue import pusb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;

  assign ready_o = cnt_q != QCNT_W'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/pusb_back.sv =====
module pusb_back import pusb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  cmd_t    q_cmd_i,
  output logic    pop_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output result_t out_res_o
);

  logic [7:0] store_mem [MAX_ROW_BYTES];
  logic [7:0] above_q;

  cmd_t       b_cmd_q;
  logic       b_valid_q, ft_sent_q;
  logic       o_valid_q;
  result_t    o_res_q, res;

  logic       o_free, b_ft_pend, b_emit, b_done, b_adv;
  logic [7:0] above;

  assign o_free    = !o_valid_q || out_ready_i;
  assign b_ft_pend = b_cmd_q.ft && !ft_sent_q;
  assign b_emit    = b_valid_q && o_free;
  assign b_done    = b_emit && !(b_ft_pend && b_cmd_q.px);
  assign b_adv     = q_valid_i && (!b_valid_q || b_done);
  assign pop_o     = b_adv;

  // Read before write at one address: old row comes out, this row goes in
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      above_q <= store_mem[q_cmd_i.addr];
      if (q_cmd_i.px && q_cmd_i.in_store) begin
        store_mem[q_cmd_i.addr] <= q_cmd_i.cur;
      end
    end
  end

  always_comb begin
    above = (b_cmd_q.first_row || !b_cmd_q.in_store) ? 8'd0 : above_q;
    if (b_ft_pend) begin
      res = '{out_byte: FILTER_TYPE_UP, is_filter_type: 1'b1, row_end: 1'b0,
              image_end: 1'b0, config_error: b_cmd_q.ce};
    end else begin
      res = '{out_byte: b_cmd_q.cur - above, is_filter_type: 1'b0,
              row_end: b_cmd_q.last, image_end: b_cmd_q.img_last,
              config_error: b_cmd_q.ce};
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      b_cmd_q <= q_cmd_i;
    end
    if (b_emit) begin
      o_res_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      ft_sent_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (b_adv) begin
        b_valid_q <= 1'b1;
      end else if (b_done) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        ft_sent_q <= 1'b0;
      end else if (b_emit && b_ft_pend) begin
        ft_sent_q <= 1'b1;
      end
      if (o_free) begin
        o_valid_q <= b_emit;
      end
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_res_o   = o_res_q;

endmodule

// ===== hw/rtl/png_up_filter_scanline_builder.sv =====
// Channel   Dir  Handshake          Payload
// sub_i     in   valid/ready        subpixel[7:0], one per padded slot of a row
// line_o    out  valid/ready        out_byte[7:0], is_filter_type, row_end,
//                                   image_end, config_error
// cfg       in   cfg_we_i (no wait) cfg_idx_i[1:0], cfg_data_i[15:0]
//
// Takes one item per cycle while the queue has room; in RGB mode a slot that opens a
// row yields two result items and holds the back end for the second, absorbed by the four-entry queue.
// A result is valid after the queue, the line store read and the output register.
// Reset sets the registers to 1 and clears control state; the line store is not
// cleared, as first-row reads of it are masked to zero. A stall on line_o fills the queue,
// after which sub_i.ready drops.
module png_up_filter_scanline_builder import pusb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  pusb_sub_if.sink             sub_i,
  pusb_line_if.source          line_o
);

  cfg_t    cfg_q;
  cmd_t    push_cmd, q_cmd;
  result_t out_res;
  logic    q_ready, push, pop, q_valid, out_valid;

  // Register file: plain writes, no read-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_width  <= CFG_W'(1);
      cfg_q.output_pixels <= CFG_W'(1);
      cfg_q.row_total     <= CFG_W'(1);
      cfg_q.rgb_mode      <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SOURCE_WIDTH:  cfg_q.source_width  <= cfg_data_i;
        REG_OUTPUT_PIXELS: cfg_q.output_pixels <= cfg_data_i;
        REG_ROW_TOTAL:     cfg_q.row_total     <= cfg_data_i;
        REG_RGB_MODE:      cfg_q.rgb_mode      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Front: track slot and row, centre, average, classify
  pusb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .valid_i    (sub_i.valid),
    .subpixel_i (sub_i.subpixel),
    .ready_o    (sub_i.ready),
    .q_ready_i  (q_ready),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  // Decouple the two halves
  pusb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .ready_o    (q_ready),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .cmd_o      (q_cmd)
  );

  // Back: line store, Up filter, result register
  pusb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .pop_o       (pop),
    .out_ready_i (line_o.ready),
    .out_valid_o (out_valid),
    .out_res_o   (out_res)
  );

  assign line_o.valid          = out_valid;
  assign line_o.out_byte       = out_res.out_byte;
  assign line_o.is_filter_type = out_res.is_filter_type;
  assign line_o.row_end        = out_res.row_end;
  assign line_o.image_end      = out_res.image_end;
  assign line_o.config_error   = out_res.config_error;

endmodule
